@@ src/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg - shared types and constants of the position frame decoder
// Frame layout, decode constants, queue entry type and grid cell helpers.
// ----------------------------------------------------------------------------
package pfd_pkg;

  // frame geometry: start byte, then 17 body bytes
  localparam int BODY_LEN    = 17;
  localparam int IDX_W       = 5;
  localparam int PAYLOAD_LEN = BODY_LEN - 1;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] FRAME_TAG  = 8'hFE;
  localparam logic [7:0] MATCH_MASK = 8'hC0;
  localparam logic [7:0] MATCH_RUN  = 8'h40;

  // payload positions: frame byte n sits at index n-2
  localparam int FB_YAW_LO = 0;
  localparam int FB_YAW_HI = 1;
  localparam int FB_FRONT  = 2;
  localparam int FB_BACK   = 3;
  localparam int FB_LEFT   = 4;
  localparam int FB_RIGHT  = 5;
  localparam int FB_FLAGS  = 6;
  localparam int FB_HIGH   = 7;
  localparam int FB_AX     = 8;
  localparam int FB_AY     = 9;
  localparam int FB_BX     = 10;
  localparam int FB_BY     = 11;
  localparam int FB_P1X    = 12;
  localparam int FB_P1Y    = 13;
  localparam int FB_P2X    = 14;
  localparam int FB_P2Y    = 15;

  // heading
  localparam logic [15:0]        YAW_OFFSET = 16'd2000;
  localparam logic signed [15:0] YAW_HALF   = 16'sd1800;
  localparam logic signed [15:0] YAW_TURN   = 16'sd3600;

  // line sensors
  localparam logic [7:0]        SENSOR_MID   = 8'd200;
  localparam logic [9:0]        ANGLE_BIAS   = 10'd160;
  localparam logic signed [9:0] OFS_FB_BACK  = 10'sd79;
  localparam logic signed [9:0] OFS_FB_FRONT = 10'sd81;
  localparam logic signed [9:0] OFS_FB_PAIR  = 10'sd2;
  localparam logic signed [9:0] OFS_LR_RIGHT = 10'sd77;
  localparam logic signed [9:0] OFS_LR_LEFT  = 10'sd83;
  localparam logic signed [9:0] OFS_LR_PAIR  = 10'sd6;

  // field and position check
  localparam logic signed [9:0] FIELD_MAX  = 10'sd280;
  localparam logic [7:0]        FAIL_LIMIT = 8'd3;
  localparam logic [7:0]        FAIL_MAX   = 8'd255;

  // grid snapping
  localparam int COORD_FLIP = 280;
  localparam int CELL_X_LO  = 56;
  localparam int CELL_Y_LO  = 72;
  localparam int CELL_ROUND = 15;
  localparam int CELL_STEP  = 30;
  localparam int CELL_MAX   = 5;

  // receive state
  typedef enum logic {
    HUNT,
    COLLECT
  } rx_state_t;

  // configuration register index
  typedef enum logic {
    REG_YAW_ZERO   = 1'b0,
    REG_CAR_SELECT = 1'b1
  } reg_index_t;

  // one complete tagged frame waiting for decode
  typedef struct packed {
    logic                            check;
    logic [PAYLOAD_LEN-1:0][7:0]     body;
  } frame_t;

  // X cell: floor((v - 56 + 15) / 30) clamped to 0..5, as threshold compares
  function automatic logic [2:0] cell_x(input logic [8:0] v);
    logic [2:0] c;
    c = '0;
    for (int k = 1; k <= CELL_MAX; k++) begin
      if (int'(v) >= CELL_X_LO - CELL_ROUND + CELL_STEP * k) c = 3'(k);
    end
    return c;
  endfunction

  // Y cell of the flipped coordinate 280 - raw, compared on the raw value
  function automatic logic [2:0] cell_y(input logic [8:0] raw);
    logic [2:0] c;
    c = '0;
    for (int k = 1; k <= CELL_MAX; k++) begin
      if (int'(raw) <= COORD_FLIP - CELL_Y_LO + CELL_ROUND - CELL_STEP * k) c = 3'(k);
    end
    return c;
  endfunction

endpackage

@@ src/pfd_byte_if.sv @@
// ----------------------------------------------------------------------------
// pfd_byte_if - received byte channel
// Valid/ready channel carrying one serial byte and its check enable per beat.
// ----------------------------------------------------------------------------
interface pfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       position_check;

  modport source (output valid, rx_byte, position_check, input ready);
  modport sink   (input valid, rx_byte, position_check, output ready);
endinterface

@@ src/pfd_result_if.sv @@
// ----------------------------------------------------------------------------
// pfd_result_if - decoded frame channel
// Valid/ready channel carrying one decoded position frame per beat.
// ----------------------------------------------------------------------------
interface pfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] yaw;
  logic signed [9:0]  offset_fb;
  logic signed [9:0]  offset_lr;
  logic signed [8:0]  angle_fb;
  logic signed [8:0]  angle_lr;
  logic [8:0]         car_x;
  logic signed [9:0]  car_y;
  logic [2:0]         p1_cell_x;
  logic [2:0]         p1_cell_y;
  logic [2:0]         p2_cell_x;
  logic [2:0]         p2_cell_y;

  modport source (output valid, status, yaw, offset_fb, offset_lr, angle_fb, angle_lr,
                  car_x, car_y, p1_cell_x, p1_cell_y, p2_cell_x, p2_cell_y,
                  input ready);
  modport sink   (input valid, status, yaw, offset_fb, offset_lr, angle_fb, angle_lr,
                  car_x, car_y, p1_cell_x, p1_cell_y, p2_cell_x, p2_cell_y,
                  output ready);
endinterface

@@ src/pfd_front.sv @@
// ----------------------------------------------------------------------------
// pfd_front - frame hunter and collector
// Hunts for the start byte, gathers 17 body bytes and pushes tagged frames.
// ----------------------------------------------------------------------------
module pfd_front import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfd_byte_if.sink  rx,
  output logic      push,
  output frame_t    push_frame,
  input  logic      q_full
);

  rx_state_t        state, state_next;
  logic [IDX_W-1:0] body_index, body_index_next;
  logic [7:0]       body_bytes [BODY_LEN];
  logic             accept;
  logic             last_byte;

  // stall only on a frame's final byte when the queue has no room
  assign last_byte = (state == COLLECT) && (body_index == IDX_W'(BODY_LEN - 1));
  assign rx.ready  = !(last_byte && q_full);
  assign accept    = rx.valid && rx.ready;
  assign push      = accept && last_byte && (body_bytes[0] == FRAME_TAG);

  // queue entry: stored bytes 2..16 plus the byte on the wire
  always_comb begin
    push_frame.check = rx.position_check;
    for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
      push_frame.body[k] = body_bytes[k + 1];
    end
    push_frame.body[PAYLOAD_LEN-1] = rx.rx_byte;
  end

  // hunt / collect sequencing
  always_comb begin
    state_next      = state;
    body_index_next = body_index;
    if (accept) begin
      case (state)
        HUNT: begin
          if (rx.rx_byte == START_BYTE) begin
            state_next      = COLLECT;
            body_index_next = '0;
          end
        end
        COLLECT: begin
          if (last_byte) begin
            state_next      = HUNT;
            body_index_next = '0;
          end else begin
            body_index_next = body_index + IDX_W'(1);
          end
        end
        default: begin
          state_next      = HUNT;
          body_index_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= HUNT;
      body_index <= '0;
    end else begin
      state      <= state_next;
      body_index <= body_index_next;
    end
  end

  // body byte store
  always_ff @(posedge clk) begin
    if (accept && (state == COLLECT)) begin
      body_bytes[body_index] <= rx.rx_byte;
    end
  end

endmodule

@@ src/pfd_queue.sv @@
// ----------------------------------------------------------------------------
// pfd_queue - frame queue
// Small FIFO of complete frames between collector and decoder.
// ----------------------------------------------------------------------------
module pfd_queue import pfd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

endmodule

@@ src/pfd_back.sv @@
// ----------------------------------------------------------------------------
// pfd_back - frame decoder
// Decodes one queued frame per beat into the result register and keeps the
// offset, position and failure history.
// ----------------------------------------------------------------------------
module pfd_back import pfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_valid,
  input  frame_t        frame,
  output logic          pop,
  input  logic [11:0]   yaw_zero,
  input  logic          car_select,
  pfd_result_if.source  res
);

  // history
  logic signed [9:0]  last_offset_fb, last_offset_lr;
  logic [8:0]         last_x;
  logic signed [9:0]  last_y;
  logic [7:0]         fail_count, fail_count_next;

  // result register
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [15:0] out_yaw;
  logic signed [9:0]  out_offset_fb, out_offset_lr;
  logic signed [8:0]  out_angle_fb, out_angle_lr;
  logic [8:0]         out_car_x;
  logic signed [9:0]  out_car_y;
  logic [2:0]         out_p1_cell_x, out_p1_cell_y, out_p2_cell_x, out_p2_cell_y;

  // decode
  logic [7:0]         f, bk, l, r, flags, high;
  logic [15:0]        yaw_raw, yaw_bias;
  logic signed [15:0] yaw_wrap, yaw_val;
  logic signed [9:0]  sf, sb, sl, sr, ofb, olr;
  logic [9:0]         sum_fb, sum_lr;
  logic signed [8:0]  afb, alr;
  logic [8:0]         x_raw, y_raw, x_val;
  logic signed [9:0]  y_flip, y_val;
  logic               pos_bad, renewed, match;

  assign pop = frame_valid && (!out_valid || res.ready);

  always_comb begin
    f     = frame.body[FB_FRONT];
    bk    = frame.body[FB_BACK];
    l     = frame.body[FB_LEFT];
    r     = frame.body[FB_RIGHT];
    flags = frame.body[FB_FLAGS];
    high  = frame.body[FB_HIGH];
    match = ((flags & MATCH_MASK) == MATCH_RUN);

    // heading: raw minus (2000 + zero), one wrap of a full turn
    yaw_raw  = {1'b0, frame.body[FB_YAW_HI], 7'b0} + {8'b0, frame.body[FB_YAW_LO]};
    yaw_bias = YAW_OFFSET + {{4{yaw_zero[11]}}, yaw_zero};
    yaw_wrap = $signed(yaw_raw - yaw_bias);
    if (yaw_wrap >= YAW_HALF) begin
      yaw_val = yaw_wrap - YAW_TURN;
    end else if (yaw_wrap < -YAW_HALF) begin
      yaw_val = yaw_wrap + YAW_TURN;
    end else begin
      yaw_val = yaw_wrap;
    end

    // line offsets; a sensor at exactly mid-scale keeps the old offset
    sf  = $signed({2'b0, f});
    sb  = $signed({2'b0, bk});
    sl  = $signed({2'b0, l});
    sr  = $signed({2'b0, r});
    ofb = last_offset_fb;
    if (f > SENSOR_MID && bk > SENSOR_MID)      ofb = '0;
    else if (f > SENSOR_MID && bk < SENSOR_MID) ofb = OFS_FB_BACK - sb;
    else if (f < SENSOR_MID && bk > SENSOR_MID) ofb = sf - OFS_FB_FRONT;
    else if (f < SENSOR_MID && bk < SENSOR_MID) ofb = sf - sb - OFS_FB_PAIR;
    olr = last_offset_lr;
    if (l > SENSOR_MID && r > SENSOR_MID)      olr = '0;
    else if (l > SENSOR_MID && r < SENSOR_MID) olr = OFS_LR_RIGHT - sr;
    else if (l < SENSOR_MID && r > SENSOR_MID) olr = sl - OFS_LR_LEFT;
    else if (l < SENSOR_MID && r < SENSOR_MID) olr = sl - sr - OFS_LR_PAIR;

    // line angles
    sum_fb = {2'b0, f} + {2'b0, bk} - ANGLE_BIAS;
    sum_lr = {2'b0, l} + {2'b0, r} - ANGLE_BIAS;
    afb    = (f < SENSOR_MID && bk < SENSOR_MID) ? $signed(sum_fb[8:0]) : '0;
    alr    = (l < SENSOR_MID && r < SENSOR_MID) ? $signed(sum_lr[8:0]) : '0;

    // own position, Y flipped
    if (car_select) begin
      x_raw = {flags[1], frame.body[FB_BX]};
      y_raw = {flags[0], frame.body[FB_BY]};
    end else begin
      x_raw = {flags[3], frame.body[FB_AX]};
      y_raw = {flags[2], frame.body[FB_AY]};
    end
    y_flip = FIELD_MAX - $signed({1'b0, y_raw});

    // optional range check with saturating failure count
    pos_bad = (x_raw == '0) || ({1'b0, x_raw} >= FIELD_MAX) ||
              (y_flip <= 10'sd0) || (y_flip >= FIELD_MAX);
    fail_count_next = fail_count;
    x_val           = x_raw;
    y_val           = y_flip;
    renewed         = 1'b1;
    if (frame.check) begin
      if (pos_bad) begin
        if (fail_count != FAIL_MAX) fail_count_next = fail_count + 8'd1;
        x_val   = last_x;
        y_val   = last_y;
        renewed = !(fail_count_next > FAIL_LIMIT);
      end else begin
        fail_count_next = '0;
      end
    end
  end

  // history and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      last_offset_fb <= '0;
      last_offset_lr <= '0;
      last_x         <= '0;
      last_y         <= '0;
      fail_count     <= '0;
    end else begin
      if (pop) begin
        out_valid      <= 1'b1;
        last_offset_fb <= ofb;
        last_offset_lr <= olr;
        last_x         <= x_val;
        last_y         <= y_val;
        fail_count     <= fail_count_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_status    <= {renewed, match};
      out_yaw       <= yaw_val;
      out_offset_fb <= ofb;
      out_offset_lr <= olr;
      out_angle_fb  <= afb;
      out_angle_lr  <= alr;
      out_car_x     <= x_val;
      out_car_y     <= y_val;
      out_p1_cell_x <= cell_x({high[7], frame.body[FB_P1X]});
      out_p1_cell_y <= cell_y({high[6], frame.body[FB_P1Y]});
      out_p2_cell_x <= cell_x({high[5], frame.body[FB_P2X]});
      out_p2_cell_y <= cell_y({high[4], frame.body[FB_P2Y]});
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.yaw       = out_yaw;
  assign res.offset_fb = out_offset_fb;
  assign res.offset_lr = out_offset_lr;
  assign res.angle_fb  = out_angle_fb;
  assign res.angle_lr  = out_angle_lr;
  assign res.car_x     = out_car_x;
  assign res.car_y     = out_car_y;
  assign res.p1_cell_x = out_p1_cell_x;
  assign res.p1_cell_y = out_p1_cell_y;
  assign res.p2_cell_x = out_p2_cell_x;
  assign res.p2_cell_y = out_p2_cell_y;

endmodule

@@ src/position_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// position_frame_decoder - serial position frame decoder
// Turns a byte stream of start-byte framed position packets into decoded
// heading, line sensor and position results.
// ----------------------------------------------------------------------------
// Takes one byte per clock. A frame is a 0xFF start byte and 17 body bytes;
// frames whose first body byte is 0xFE produce one result, others none. A
// complete frame goes through a QUEUE_DEPTH entry frame queue to the decoder,
// which decodes one frame per cycle, unless the output stalls, into a
// registered result. With the queue empty and the output free, a frame
// goes from the queue into the result register. Behind a stalled output up
// to QUEUE_DEPTH frames wait in the queue plus one in the result register;
// the input stalls only on a frame's last byte while that queue is full.
// Registers: yaw_zero at byte address 0, car_select at byte address 4.
module position_frame_decoder import pfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  pfd_byte_if.sink      rx,
  pfd_result_if.source  res
);

  logic [11:0] yaw_zero;
  logic        car_select;
  reg_index_t  reg_index;
  logic        cfg_write;
  logic        push, pop, q_full, q_empty;
  frame_t      push_frame, head;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_zero   <= '0;
      car_select <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_YAW_ZERO:   yaw_zero   <= pwdata[11:0];
        REG_CAR_SELECT: car_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_YAW_ZERO:   prdata = {20'b0, yaw_zero};
      REG_CAR_SELECT: prdata = {31'b0, car_select};
      default:        prdata = '0;
    endcase
  end

  // collector -> queue -> decoder
  pfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push       (push),
    .push_frame (push_frame),
    .q_full     (q_full)
  );

  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  pfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (!q_empty),
    .frame       (head),
    .pop         (pop),
    .yaw_zero    (yaw_zero),
    .car_select  (car_select),
    .res         (res)
  );

endmodule

@@ src/pfd_checker.sv @@
// ----------------------------------------------------------------------------
// pfd_checker - port level checks
// Watches the decoder's channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               rx_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         res_status,
  input logic signed [15:0] res_yaw,
  input logic [2:0]         res_p1_cell_x,
  input logic [2:0]         res_p1_cell_y,
  input logic [2:0]         res_p2_cell_x,
  input logic [2:0]         res_p2_cell_y
);

  // no result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // input back-pressure only while a result waits on the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid)
    else $error("input stalled with empty output");

  // grid cells stay on the 0..5 grid
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_p1_cell_x <= 3'd5) && (res_p1_cell_y <= 3'd5) &&
                  (res_p2_cell_x <= 3'd5) && (res_p2_cell_y <= 3'd5))
    else $error("grid cell out of range");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_yaw) && $stable(res_status))
    else $error("stalled result changed");

endmodule

bind position_frame_decoder pfd_checker u_pfd_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_ready      (rx.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_status    (res.status),
  .res_yaw       (res.yaw),
  .res_p1_cell_x (res.p1_cell_x),
  .res_p1_cell_y (res.p1_cell_y),
  .res_p2_cell_x (res.p2_cell_x),
  .res_p2_cell_y (res.p2_cell_y)
);

@@ verif/pfd_frame_checker.sv @@
// ----------------------------------------------------------------------------
// pfd_frame_checker - decoded frame predictor and comparator
// Follows the APB writes and the received byte beats, rebuilds every decoded
// frame on its own and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_frame_checker import pfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  pfd_byte_if         rx,
  pfd_result_if       res,
  output int          mismatches,
  output int          pending,
  output int          results_checked
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] yaw;
    logic [9:0]  offset_fb;
    logic [9:0]  offset_lr;
    logic [8:0]  angle_fb;
    logic [8:0]  angle_lr;
    logic [8:0]  car_x;
    logic [9:0]  car_y;
    logic [2:0]  p1_cell_x;
    logic [2:0]  p1_cell_y;
    logic [2:0]  p2_cell_x;
    logic [2:0]  p2_cell_y;
  } decoded_t;

  decoded_t decoded_q[$];

  // shadow of the configuration registers
  logic signed [11:0] yaw_zero_r;
  logic               car_sel_r;

  // shadow of the receive and tracking state
  rx_state_t  rx_phase;
  int         body_cnt;
  logic [7:0] body [1:17];
  int         last_x;
  int         last_y;
  int         fail_cnt;
  int         last_ofs_fb;
  int         last_ofs_lr;

  // rounded grid snap, clamped to 0..5
  function automatic int grid_cell(input int v, input int lower);
    int n;
    n = v - lower + CELL_ROUND;
    if (n < 0) return 0;
    n = n / CELL_STEP;
    return (n > CELL_MAX) ? CELL_MAX : n;
  endfunction

  // one byte into the frame tracker; returns 1 when a decoded frame results
  function automatic bit take_rx_byte(input logic [7:0] b, input logic chk,
                                      output decoded_t d);
    int         yaw_v, ofb, olr, afb, alr, x, y, p1x, p1y, p2x, p2y;
    int         f, bk, l, r;
    logic [15:0] yaw16;
    logic [7:0]  b8, b9;
    logic        renewed;
    d = '0;
    if (rx_phase == HUNT) begin
      if (b == START_BYTE) begin
        rx_phase = COLLECT;
        body_cnt = 0;
      end
      return 0;
    end
    body_cnt++;
    body[body_cnt] = b;
    if (body_cnt < BODY_LEN) return 0;
    rx_phase = HUNT;
    body_cnt = 0;
    if (body[1] != FRAME_TAG) return 0;

    b8 = body[8];
    b9 = body[9];

    // heading: 16-bit wrap on each subtraction, then one half-turn fold
    yaw16 = 16'(body[2]) + (16'(body[3]) << 7);
    yaw16 = yaw16 - 16'd2000;
    yaw16 = yaw16 - {{4{yaw_zero_r[11]}}, yaw_zero_r};
    yaw_v = int'($signed(yaw16));
    if (yaw_v >= 1800) yaw_v -= 3600;
    else if (yaw_v < -1800) yaw_v += 3600;

    // line sensors; a reading of exactly 200 may leave the old offset
    f  = int'(body[4]);
    bk = int'(body[5]);
    l  = int'(body[6]);
    r  = int'(body[7]);
    ofb = last_ofs_fb;
    if (f > 200 && bk > 200) ofb = 0;
    else if (f > 200 && bk < 200) ofb = 79 - bk;
    else if (f < 200 && bk > 200) ofb = f - 81;
    else if (f < 200 && bk < 200) ofb = f - bk - 2;
    olr = last_ofs_lr;
    if (l > 200 && r > 200) olr = 0;
    else if (l > 200 && r < 200) olr = 77 - r;
    else if (l < 200 && r > 200) olr = l - 83;
    else if (l < 200 && r < 200) olr = l - r - 6;
    last_ofs_fb = ofb;
    last_ofs_lr = olr;
    afb = (f < 200 && bk < 200) ? f + bk - 160 : 0;
    alr = (l < 200 && r < 200) ? l + r - 160 : 0;

    // own position and the two target points, Y flipped
    if (!car_sel_r) begin
      x = int'(body[10]) + (b8[3] ? 256 : 0);
      y = int'(body[11]) + (b8[2] ? 256 : 0);
    end else begin
      x = int'(body[12]) + (b8[1] ? 256 : 0);
      y = int'(body[13]) + (b8[0] ? 256 : 0);
    end
    y   = 280 - y;
    p1x = int'(body[14]) + (b9[7] ? 256 : 0);
    p1y = 280 - (int'(body[15]) + (b9[6] ? 256 : 0));
    p2x = int'(body[16]) + (b9[5] ? 256 : 0);
    p2y = 280 - (int'(body[17]) + (b9[4] ? 256 : 0));

    // field check: hold last position, drop renewed after three failures
    renewed = 1'b1;
    if (chk) begin
      if (x <= 0 || x >= 280 || y <= 0 || y >= 280) begin
        if (fail_cnt < 255) fail_cnt++;
        x = last_x;
        y = last_y;
        if (fail_cnt > 3) renewed = 1'b0;
      end else begin
        fail_cnt = 0;
      end
    end
    last_x = x;
    last_y = y;

    d.status    = {renewed, (b8 & MATCH_MASK) == MATCH_RUN};
    d.yaw       = 16'(yaw_v);
    d.offset_fb = 10'(ofb);
    d.offset_lr = 10'(olr);
    d.angle_fb  = 9'(afb);
    d.angle_lr  = 9'(alr);
    d.car_x     = 9'(x);
    d.car_y     = 10'(y);
    d.p1_cell_x = 3'(grid_cell(p1x, CELL_X_LO));
    d.p1_cell_y = 3'(grid_cell(p1y, CELL_Y_LO));
    d.p2_cell_x = 3'(grid_cell(p2x, CELL_X_LO));
    d.p2_cell_y = 3'(grid_cell(p2y, CELL_Y_LO));
    return 1;
  endfunction

  function automatic string show(input decoded_t d);
    return $sformatf("st=%0d yaw=%0d ofb=%0d olr=%0d afb=%0d alr=%0d x=%0d y=%0d cells=%0d,%0d %0d,%0d",
                     d.status, $signed(d.yaw), $signed(d.offset_fb), $signed(d.offset_lr),
                     $signed(d.angle_fb), $signed(d.angle_lr), d.car_x, $signed(d.car_y),
                     d.p1_cell_x, d.p1_cell_y, d.p2_cell_x, d.p2_cell_y);
  endfunction

  // config tracking, result compare, then prediction of the new byte
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    decoded_t d;
    string    bad;
    if (rst) begin
      yaw_zero_r      = '0;
      car_sel_r       = 1'b0;
      rx_phase        = HUNT;
      body_cnt        = 0;
      last_x          = 0;
      last_y          = 0;
      fail_cnt        = 0;
      last_ofs_fb     = 0;
      last_ofs_lr     = 0;
      mismatches      = 0;
      results_checked = 0;
      decoded_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_index_t'(paddr[2]) == REG_YAW_ZERO) yaw_zero_r = pwdata[11:0];
        else car_sel_r = pwdata[0];
      end

      if (res.valid && res.ready) begin
        got.status    = res.status;
        got.yaw       = res.yaw;
        got.offset_fb = res.offset_fb;
        got.offset_lr = res.offset_lr;
        got.angle_fb  = res.angle_fb;
        got.angle_lr  = res.angle_lr;
        got.car_x     = res.car_x;
        got.car_y     = res.car_y;
        got.p1_cell_x = res.p1_cell_x;
        got.p1_cell_y = res.p1_cell_y;
        got.p2_cell_x = res.p2_cell_x;
        got.p2_cell_y = res.p2_cell_y;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: result beat with none expected: %s", $time, show(got));
        end else begin
          want = decoded_q.pop_front();
          results_checked++;
          bad = "";
          if (got.status    !== want.status)    bad = {bad, " status"};
          if (got.yaw       !== want.yaw)       bad = {bad, " yaw"};
          if (got.offset_fb !== want.offset_fb) bad = {bad, " offset_fb"};
          if (got.offset_lr !== want.offset_lr) bad = {bad, " offset_lr"};
          if (got.angle_fb  !== want.angle_fb)  bad = {bad, " angle_fb"};
          if (got.angle_lr  !== want.angle_lr)  bad = {bad, " angle_lr"};
          if (got.car_x     !== want.car_x)     bad = {bad, " car_x"};
          if (got.car_y     !== want.car_y)     bad = {bad, " car_y"};
          if (got.p1_cell_x !== want.p1_cell_x) bad = {bad, " p1_cell_x"};
          if (got.p1_cell_y !== want.p1_cell_y) bad = {bad, " p1_cell_y"};
          if (got.p2_cell_x !== want.p2_cell_x) bad = {bad, " p2_cell_x"};
          if (got.p2_cell_y !== want.p2_cell_y) bad = {bad, " p2_cell_y"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR %0t: result %0d differs in%s", $time, results_checked, bad);
              $display("  exp %s", show(want));
              $display("  act %s", show(got));
            end
          end
        end
      end

      if (rx.valid && rx.ready) begin
        if (take_rx_byte(rx.rx_byte, rx.position_check, d)) decoded_q.push_back(d);
      end
    end
    pending = decoded_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - position frame decoder testbench
// Drives framed byte streams and register settings into the decoder with
// random gaps and output stalls; the frame checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pfd_pkg::*;

  localparam int BEAT_GOAL     = 1950;
  localparam int PHASES        = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pfd_byte_if   rx_ch ();
  pfd_result_if res_ch ();

  int mismatches;
  int pending;
  int results_checked;

  logic [7:0]  frame_buf [1:17];
  int          rx_beats    = 0;
  int          frames_sent = 0;
  int          reg_writes  = 0;
  logic        quiet       = 1'b0;
  int          hold_asks   = 0;
  int          hold_served = 0;
  int unsigned cycle_count = 0;

  position_frame_decoder DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .res     (res_ch)
  );

  pfd_frame_checker u_frame_chk (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .rx              (rx_ch),
    .res             (res_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("position_frame_decoder: mismatch");
    $finish;
  end

  // result sink: random stalls, one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ch.ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic chk);
    if (!quiet && $urandom_range(99) < 9) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid          <= 1'b1;
    rx_ch.rx_byte        <= b;
    rx_ch.position_check <= chk;
    do @(posedge clk); while (!rx_ch.ready);
    rx_beats++;
  endtask

  // start byte plus 17 body bytes; mixed gives each beat its own check bit
  task automatic send_frame(input logic chk, input bit mixed);
    send_byte(START_BYTE, chk);
    for (int i = 1; i <= BODY_LEN; i++)
      send_byte(frame_buf[i], mixed ? 1'($urandom_range(1)) : chk);
    frames_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // stop offering beats and wait until every predicted result has come out
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------ frame build

  // in-field frame: yaw reads zero, all sensors at 100, both cars at 100,100
  function automatic void base_frame();
    frame_buf[1] = FRAME_TAG;
    frame_buf[2] = 8'h50;
    frame_buf[3] = 8'h0F;
    for (int i = 4; i <= 7; i++) frame_buf[i] = 8'd100;
    frame_buf[8] = MATCH_RUN;
    frame_buf[9] = 8'h00;
    for (int i = 10; i <= 13; i++) frame_buf[i] = 8'd100;
    frame_buf[14] = 8'd56;
    frame_buf[15] = 8'd208;
    frame_buf[16] = 8'd206;
    frame_buf[17] = 8'd58;
  endfunction

  function automatic void set_sensors(input logic [7:0] f, input logic [7:0] b,
                                      input logic [7:0] l, input logic [7:0] r);
    frame_buf[4] = f;
    frame_buf[5] = b;
    frame_buf[6] = l;
    frame_buf[7] = r;
  endfunction

  // sensor values clustered around the 200 threshold
  function automatic logic [7:0] pick_sensor();
    case ($urandom_range(7))
      0:       return 8'd200;
      1:       return 8'd199;
      2:       return 8'd201;
      3:       return 8'd0;
      4:       return 8'd255;
      5:       return 8'($urandom_range(250, 150));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // coordinate low bytes near the field edges 0 and 280
  function automatic logic [7:0] pick_coord();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd23;
      3:       return 8'd24;
      4:       return 8'd25;
      5:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void random_frame(input bit with_tag, input bit off_field);
    logic [7:0] tag;
    tag = 8'($urandom_range(255));
    frame_buf[1] = with_tag ? FRAME_TAG : ((tag == FRAME_TAG) ? 8'h00 : tag);
    frame_buf[2] = 8'($urandom_range(255));
    frame_buf[3] = 8'($urandom_range(255));
    for (int i = 4; i <= 7; i++) frame_buf[i] = pick_sensor();
    frame_buf[8] = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) frame_buf[8][7:6] = 2'b01;
    frame_buf[9] = 8'($urandom_range(255));
    for (int i = 10; i <= 13; i++) frame_buf[i] = pick_coord();
    for (int i = 14; i <= 17; i++) frame_buf[i] = 8'($urandom_range(255));
    // X of both cars at zero: rejected whichever car is selected
    if (off_field) begin
      frame_buf[10]   = 8'd0;
      frame_buf[12]   = 8'd0;
      frame_buf[8][3] = 1'b0;
      frame_buf[8][1] = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    int  goal;
    int  yz;
    int  bad_run;
    bit  with_tag;
    logic chk;

    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    rx_ch.valid          <= 1'b0;
    rx_ch.rx_byte        <= '0;
    rx_ch.position_check <= 1'b0;
    bad_run = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bytes ignored while hunting
    send_byte(8'h00, 1'b0);
    send_byte(FRAME_TAG, 1'b1);

    // directed: sensor pair cases, with and without the 200 hold
    base_frame();
    set_sensors(8'd255, 8'd255, 8'd255, 8'd255);
    frame_buf[2] = 8'h00;
    frame_buf[3] = 8'h00;
    send_frame(1'b0, 1'b0);
    base_frame();
    set_sensors(8'd200, 8'd100, 8'd100, 8'd255);
    send_frame(1'b0, 1'b0);
    base_frame();
    set_sensors(8'd255, 8'd0, 8'd255, 8'd199);
    send_frame(1'b1, 1'b0);
    base_frame();
    set_sensors(8'd0, 8'd199, 8'd199, 8'd0);
    send_frame(1'b0, 1'b0);
    base_frame();
    set_sensors(8'd200, 8'd200, 8'd200, 8'd201);
    send_frame(1'b0, 1'b0);
    base_frame();
    set_sensors(8'd201, 8'd200, 8'd200, 8'd199);
    send_frame(1'b0, 1'b0);

    // directed: untagged frame with start bytes inside the body
    base_frame();
    frame_buf[1]  = 8'h00;
    frame_buf[5]  = START_BYTE;
    frame_buf[12] = START_BYTE;
    send_frame(1'b0, 1'b0);

    // directed: tagged all-ones body (raw yaw wraps, 511 coordinates)
    base_frame();
    for (int i = 2; i <= BODY_LEN; i++) frame_buf[i] = 8'hFF;
    send_frame(1'b0, 1'b0);

    // directed: heading fold edges at +1800 and just below -1800
    base_frame();
    frame_buf[2] = 8'd88;
    frame_buf[3] = 8'd29;
    send_frame(1'b0, 1'b0);
    base_frame();
    frame_buf[2] = 8'd199;
    frame_buf[3] = 8'd0;
    send_frame(1'b0, 1'b0);

    // directed: rejection streak past three, then recovery, then Y edge
    repeat (5) begin
      base_frame();
      frame_buf[10] = 8'd0;
      send_frame(1'b1, 1'b0);
    end
    base_frame();
    send_frame(1'b1, 1'b0);
    base_frame();
    frame_buf[8]  = 8'h48;
    frame_buf[10] = 8'd23;
    frame_buf[11] = 8'd0;
    send_frame(1'b1, 1'b0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       yz = -1800;
        1:       yz = 1799;
        2:       yz = 0;
        4:       yz = -1;
        default: yz = int'($urandom_range(3599)) - 1800;
      endcase
      write_reg(REG_YAW_ZERO, 32'(yz));
      write_reg(REG_CAR_SELECT, 32'(ph % 2 == 0));
      quiet <= (ph == 3);
      if (ph == 1) hold_asks <= hold_asks + 1;
      goal = BEAT_GOAL * (ph + 1) / PHASES;
      while (rx_beats < goal) begin
        // line noise between frames
        if ($urandom_range(99) < 30)
          repeat ($urandom_range(3, 1))
            send_byte(8'($urandom_range(254)), 1'($urandom_range(1)));
        // cut-off frame: the next start byte lands inside its body
        if ($urandom_range(99) < 4) begin
          send_byte(START_BYTE, 1'b0);
          repeat ($urandom_range(16, 1))
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        if (bad_run == 0 && $urandom_range(99) < 5) bad_run = $urandom_range(7, 3);
        with_tag = $urandom_range(99) < 88;
        random_frame(with_tag, bad_run > 0);
        chk = (bad_run > 0) ? 1'b1 : 1'($urandom_range(1));
        send_frame(chk, bad_run == 0 && $urandom_range(99) < 20);
        if (bad_run > 0) bad_run--;
      end
    end
    settle();

    $display("covered %0d frames in %0d byte beats over %0d register writes",
             frames_sent, rx_beats, reg_writes);
    $display("%0d decoded results compared, %0d failures, %0d still outstanding",
             results_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0)
      $display("position_frame_decoder: match");
    else
      $display("position_frame_decoder: mismatch");
    $finish;
  end

endmodule
